>>> hdl/ltjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltjd_pkg
// Shared constants for the label triple junction detector: coordinate and
// configuration widths, row saturation limit and the image width after reset.
// ----------------------------------------------------------------------------
package ltjd_pkg;

  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned CFG_BITS    = 13;
  localparam logic [COORD_BITS-1:0] ROW_MAX = 12'd4095;
  localparam logic [CFG_BITS-1:0]   RESET_WIDTH = 13'd640;

endpackage : ltjd_pkg
`default_nettype wire

>>> hdl/label_triple_junction_detector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// label_triple_junction_detector
// Streams a label image in raster order, keeps the previous row in a line
// memory and reports every 2x2 window that holds exactly three distinct labels.
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// pixel     in         in_valid / in_ready     pixel_label, frame_start
// junction  out        out_valid / out_ready   corner_x, corner_y,
//                                              label_low, label_mid, label_high
// config    in         cfg_we                  cfg_wdata (image width)
//
// one pixel per cycle is accepted while no stalled junction holds the window stage;
// a junction is registered in the window stage, then in the output register
// the line memory is read and written at the same address in the transfer cycle
// a stalled junction holds the window stage and blocks further pixels
// reset clears position counters and neighbor labels, not the line memory
// ----------------------------------------------------------------------------
module label_triple_junction_detector #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned LABEL_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_we,
  input  wire logic [ltjd_pkg::CFG_BITS-1:0]         cfg_wdata,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic [LABEL_BITS-1:0]                 pixel_label,
  input  wire logic                                  frame_start,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [ltjd_pkg::COORD_BITS-1:0]            corner_x,
  output logic [ltjd_pkg::COORD_BITS-1:0]            corner_y,
  output logic [LABEL_BITS-1:0]                      label_low,
  output logic [LABEL_BITS-1:0]                      label_mid,
  output logic [LABEL_BITS-1:0]                      label_high
);

  localparam int unsigned CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned YW = ltjd_pkg::COORD_BITS;

  function automatic logic [CW-1:0] last_col_of(input logic [ltjd_pkg::CFG_BITS-1:0] w);
    logic [CW-1:0] r;
    if (w < 13'd2) begin
      r = CW'(1);
    end else if (32'(w) > MAX_WIDTH) begin
      r = CW'(MAX_WIDTH - 1);
    end else begin
      r = CW'(w - 13'd1);
    end
    return r;
  endfunction

  // line memory
  logic [LABEL_BITS-1:0] row_store [MAX_WIDTH];
  logic [LABEL_BITS-1:0] up_label;

  // position state
  logic [CW-1:0] last_col;
  logic [CW-1:0] column_count;
  logic [YW-1:0] row_count;
  logic [CW-1:0] col_cur;
  logic [YW-1:0] row_cur;
  logic [CW-1:0] column_count_next;
  logic [YW-1:0] row_count_next;
  logic          in_xfer;

  // window stage
  logic                  s1_valid;
  logic                  s1_win;
  logic [CW-1:0]         s1_cx;
  logic [YW-1:0]         s1_cy;
  logic [LABEL_BITS-1:0] s1_pix;
  logic [LABEL_BITS-1:0] left_label;
  logic [LABEL_BITS-1:0] upper_left_label;
  logic                  s1_go;
  logic                  s1_hit;

  // sorting network
  logic [LABEL_BITS-1:0] a0, a1, a2, a3;
  logic [LABEL_BITS-1:0] b0, b1, b2, b3;
  logic [LABEL_BITS-1:0] c1, c2;
  logic                  e01, e12, e23;
  logic [LABEL_BITS-1:0] r_low, r_mid, r_high;

  assign in_xfer = in_valid && in_ready;
  assign col_cur = frame_start ? '0 : column_count;
  assign row_cur = frame_start ? '0 : row_count;

  always_comb begin
    if (col_cur >= last_col) begin
      column_count_next = '0;
      row_count_next    = (row_cur < ltjd_pkg::ROW_MAX) ? row_cur + YW'(1) : row_cur;
    end else begin
      column_count_next = col_cur + CW'(1);
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col <= last_col_of(ltjd_pkg::RESET_WIDTH);
    end else if (cfg_we) begin
      last_col <= last_col_of(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_xfer) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // read-first line memory
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      up_label           <= row_store[col_cur];
      row_store[col_cur] <= pixel_label;
    end
  end

  // window stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_win <= (col_cur != '0) && (row_cur != '0);
      s1_cx  <= col_cur - CW'(1);
      s1_cy  <= row_cur - YW'(1);
      s1_pix <= pixel_label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_label       <= '0;
      upper_left_label <= '0;
    end else if (s1_go) begin
      left_label       <= s1_pix;
      upper_left_label <= up_label;
    end
  end

  always_comb begin
    if (upper_left_label > up_label) begin
      a0 = up_label;
      a1 = upper_left_label;
    end else begin
      a0 = upper_left_label;
      a1 = up_label;
    end
    if (left_label > s1_pix) begin
      a2 = s1_pix;
      a3 = left_label;
    end else begin
      a2 = left_label;
      a3 = s1_pix;
    end
    b0 = (a0 > a2) ? a2 : a0;
    b2 = (a0 > a2) ? a0 : a2;
    b1 = (a1 > a3) ? a3 : a1;
    b3 = (a1 > a3) ? a1 : a3;
    c1 = (b1 > b2) ? b2 : b1;
    c2 = (b1 > b2) ? b1 : b2;
    e01 = (b0 == c1);
    e12 = (c1 == c2);
    e23 = (c2 == b3);
    priority if (e01) begin
      r_low = b0;
      r_mid = c2;
      r_high = b3;
    end else if (e12) begin
      r_low = b0;
      r_mid = c1;
      r_high = b3;
    end else begin
      r_low = b0;
      r_mid = c1;
      r_high = c2;
    end
  end

  assign s1_hit   = s1_win && ((32'(e01) + 32'(e12) + 32'(e23)) == 32'd1);
  assign s1_go    = s1_valid && (!s1_hit || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_hit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_hit) begin
      corner_x   <= YW'(s1_cx);
      corner_y   <= s1_cy;
      label_low  <= r_low;
      label_mid  <= r_mid;
      label_high <= r_high;
    end
  end

endmodule : label_triple_junction_detector
`default_nettype wire

>>> hdl/ltjd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltjd_checker
// Port-level checks for the label triple junction detector, bound to the top.
// ----------------------------------------------------------------------------
module ltjd_checker #(
  parameter int unsigned LABEL_BITS = 16
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [ltjd_pkg::COORD_BITS-1:0]   corner_x,
  input wire logic [ltjd_pkg::COORD_BITS-1:0]   corner_y,
  input wire logic [LABEL_BITS-1:0]             label_low,
  input wire logic [LABEL_BITS-1:0]             label_mid,
  input wire logic [LABEL_BITS-1:0]             label_high
);

  // held junction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(corner_x) && $stable(corner_y)
      && $stable(label_low) && $stable(label_mid) && $stable(label_high))
    else $error("junction changed while stalled");

  // labels strictly ascending
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (label_low < label_mid) && (label_mid < label_high))
    else $error("junction labels not strictly ascending");

  // corner never on the last possible column
  a_corner: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> corner_x != {ltjd_pkg::COORD_BITS{1'b1}})
    else $error("junction corner column out of range");

  // empty output slot never blocks pixels
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pixel input blocked with free output");

  // nothing pending right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("junction valid after reset");

endmodule : ltjd_checker

bind label_triple_junction_detector ltjd_checker #(
  .LABEL_BITS(LABEL_BITS)
) u_ltjd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .corner_x   (corner_x),
  .corner_y   (corner_y),
  .label_low  (label_low),
  .label_mid  (label_mid),
  .label_high (label_high)
);
`default_nettype wire

>>> test/ltjd_junction_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltjd_junction_checker
// Watches the pixel, junction and width ports of the triple junction
// detector. It keeps its own line store, neighbor labels and position
// counters, predicts the junction each pixel transfer completes, and compares
// every junction transfer field by field with the oldest predicted junction.
// ----------------------------------------------------------------------------
module ltjd_junction_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ltjd_pkg::CFG_BITS-1:0]   cfg_wdata,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [15:0]                     pixel_label,
  input  wire logic                            frame_start,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [ltjd_pkg::COORD_BITS-1:0] corner_x,
  input  wire logic [ltjd_pkg::COORD_BITS-1:0] corner_y,
  input  wire logic [15:0]                     label_low,
  input  wire logic [15:0]                     label_mid,
  input  wire logic [15:0]                     label_high,
  output int unsigned                          fail_count,
  output int unsigned                          pending_count,
  output int unsigned                          pixel_count,
  output int unsigned                          junction_count
);

  typedef struct packed {
    logic [ltjd_pkg::COORD_BITS-1:0] x;
    logic [ltjd_pkg::COORD_BITS-1:0] y;
    logic [15:0]                     lo;
    logic [15:0]                     mid;
    logic [15:0]                     hi;
  } junction_t;

  logic [15:0]                     line_store [0:4095];
  logic [15:0]                     left_lbl;
  logic [15:0]                     upper_left_lbl;
  logic [ltjd_pkg::COORD_BITS-1:0] col_pos;
  logic [ltjd_pkg::COORD_BITS-1:0] row_pos;
  logic [ltjd_pkg::CFG_BITS-1:0]   width_reg;
  junction_t                       junction_q [$];
  int unsigned                     errors;
  int unsigned                     accepted;
  int unsigned                     checked;

  task automatic predict_junction(input logic [15:0] pix, input logic fs);
    logic [15:0]                   above;
    logic [15:0]                   win [0:3];
    logic [15:0]                   uniq [0:2];
    logic [15:0]                   tmp;
    logic [ltjd_pkg::CFG_BITS-1:0] span;
    int                            n;
    junction_t                     jn;
    span = (width_reg < 13'd2) ? 13'd2 : (width_reg > 13'd4096) ? 13'd4096 : width_reg;
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    above = line_store[col_pos];
    if (col_pos != '0 && row_pos != '0) begin
      win[0] = upper_left_lbl;
      win[1] = above;
      win[2] = left_lbl;
      win[3] = pix;
      for (int i = 1; i < 4; i++) begin
        for (int j = i; j > 0; j--) begin
          if (win[j-1] > win[j]) begin
            tmp      = win[j];
            win[j]   = win[j-1];
            win[j-1] = tmp;
          end
        end
      end
      n = 0;
      for (int i = 0; i < 4; i++) begin
        if (i == 0 || win[i] != win[i-1]) begin
          if (n < 3) uniq[n] = win[i];
          n++;
        end
      end
      if (n == 3) begin
        jn.x   = col_pos - 1'b1;
        jn.y   = row_pos - 1'b1;
        jn.lo  = uniq[0];
        jn.mid = uniq[1];
        jn.hi  = uniq[2];
        junction_q = {junction_q, jn};
      end
    end
    upper_left_lbl       = above;
    left_lbl             = pix;
    line_store[col_pos]  = pix;
    if ({1'b0, col_pos} + 13'd1 >= span) begin
      col_pos = '0;
      if (row_pos != ltjd_pkg::ROW_MAX) row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  task automatic check_junction();
    junction_t exp_j;
    if (junction_q.size() == 0) begin
      errors++;
      if (errors <= 40)
        $display("%0t: junction (%0d,%0d) %0d %0d %0d with none predicted, expected none",
                 $time, corner_x, corner_y, label_low, label_mid, label_high);
    end else begin
      exp_j = junction_q.pop_front();
      checked++;
      compare_field("corner_x", exp_j.x, corner_x);
      compare_field("corner_y", exp_j.y, corner_y);
      compare_field("label_low", exp_j.lo, label_low);
      compare_field("label_mid", exp_j.mid, label_mid);
      compare_field("label_high", exp_j.hi, label_high);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4096; k++) line_store[k] = '0;
      left_lbl       = '0;
      upper_left_lbl = '0;
      col_pos        = '0;
      row_pos        = '0;
      width_reg      = ltjd_pkg::RESET_WIDTH;
      junction_q.delete();
      errors         = 0;
      accepted       = 0;
      checked        = 0;
    end else begin
      if (cfg_we) width_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        accepted++;
        predict_junction(pixel_label, frame_start);
      end
      if (out_valid && out_ready) check_junction();
    end
    fail_count     <= errors;
    pending_count  <= junction_q.size();
    pixel_count    <= accepted;
    junction_count <= checked;
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives label images into the triple junction detector with random gaps on
// both channels: a default-width image, a short hand-picked sequence, an
// oversized width code, a width cut inside a frame, a long output stall and
// random frames at random widths. The checker predicts and compares; this
// module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam logic [15:0] DIRECTED_LABELS [0:22] = '{
    16'd0, 16'd65535, 16'd1, 16'd65535, 16'd1, 16'd1, 16'd2, 16'd3,
    16'd4, 16'd5, 16'd4, 16'd5, 16'd7, 16'd7, 16'd7, 16'd7, 16'd9,
    16'd65535, 16'd0, 16'd65535, 16'd0, 16'hAAAA, 16'd0
  };
  localparam int unsigned DIRECTED_RESTART = 17;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [ltjd_pkg::CFG_BITS-1:0]   cfg_wdata;
  logic                            in_valid;
  logic                            in_ready;
  logic [15:0]                     pixel_label;
  logic                            frame_start;
  logic                            out_valid;
  logic                            out_ready;
  logic [ltjd_pkg::COORD_BITS-1:0] corner_x;
  logic [ltjd_pkg::COORD_BITS-1:0] corner_y;
  logic [15:0]                     label_low;
  logic [15:0]                     label_mid;
  logic [15:0]                     label_high;

  wire [31:0]  fail_count;
  wire [31:0]  pending_count;
  wire [31:0]  pixel_count;
  wire [31:0]  junction_count;

  bit          send_gaps = 1'b1;
  bit          take_gaps = 1'b1;
  bit          hold_req  = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned width_writes = 0;
  logic [15:0] palette [0:3];

  label_triple_junction_detector DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_label (pixel_label),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .corner_x    (corner_x),
    .corner_y    (corner_y),
    .label_low   (label_low),
    .label_mid   (label_mid),
    .label_high  (label_high)
  );

  ltjd_junction_checker junction_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .pixel_label    (pixel_label),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .corner_x       (corner_x),
    .corner_y       (corner_y),
    .label_low      (label_low),
    .label_mid      (label_mid),
    .label_high     (label_high),
    .fail_count     (fail_count),
    .pending_count  (pending_count),
    .pixel_count    (pixel_count),
    .junction_count (junction_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("cycle limit of %0d reached with %0d junctions pending",
               LIMIT_CYCLES, pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // junction side: per-transfer random hold-off, one long stall on request
  initial begin : junction_sink
    int unsigned gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      gap = take_gaps ? $urandom_range(0, 11) : 0;
      if (hold_req) begin
        gap      = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic put_pixel(input logic [15:0] lbl, input logic fs);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_label <= lbl;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_junctions();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [ltjd_pkg::CFG_BITS-1:0] w);
    drain_junctions();
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    width_writes++;
  endtask

  task automatic new_palette();
    for (int i = 0; i < 4; i++) palette[i] = 16'($urandom_range(0, 65535));
  endtask

  // mostly palette labels so junctions are common, some noise labels,
  // and optionally a rare frame restart in the middle of the stream
  task automatic send_run(input int unsigned count, input bit first_fs, input bit restarts);
    logic [15:0] lbl;
    logic        fs;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) lbl = 16'($urandom_range(0, 65535));
      else lbl = palette[$urandom_range(0, 3)];
      if (i == 0) fs = first_fs;
      else fs = restarts && ($urandom_range(0, 299) == 0);
      put_pixel(lbl, fs);
    end
  endtask

  initial begin : stimulus
    logic [ltjd_pkg::CFG_BITS-1:0] w;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    pixel_label <= '0;
    frame_start <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // width after reset; the first row fills the line store columns used later
    new_palette();
    send_run(644, 1'b1, 1'b0);

    // hand-picked windows at the narrowest width, labels at both extremes
    write_width(13'd0);
    for (int i = 0; i < 23; i++)
      put_pixel(DIRECTED_LABELS[i], i == 0 || i == DIRECTED_RESTART);
    write_width(13'd1);
    send_run(3, 1'b0, 1'b0);

    // oversized code acts as the widest row
    write_width(13'd8191);
    send_run(40, 1'b1, 1'b0);
    write_width(13'd4096);
    send_run(20, 1'b0, 1'b0);

    // narrower width while the column is past it
    write_width(13'd3);
    send_run(30, 1'b0, 1'b0);

    for (int k = 0; k < 10; k++) begin
      if ($urandom_range(0, 3) == 0) w = 13'($urandom_range(0, 8191));
      else w = 13'($urandom_range(2, 24));
      write_width(w);
      send_gaps = $urandom_range(0, 3) != 0;
      take_gaps = $urandom_range(0, 3) != 0;
      if (k == 0) begin
        send_gaps = 1'b0;
        hold_req  = 1'b1;
      end
      new_palette();
      send_run($urandom_range(20, 35), $urandom_range(0, 1), 1'b1);
    end

    drain_junctions();
    repeat (16) @(posedge clk);
    $display("%0d pixel transfers and %0d junction transfers over %0d width writes",
             pixel_count, junction_count, width_writes);
    $display("widths 0..8191 with clamping, mid-frame cut, frame restarts, long stall");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/ltjd_pkg.sv
hdl/label_triple_junction_detector.sv
hdl/ltjd_checker.sv
test/ltjd_junction_checker.sv
test/tb.sv
